// ===== design/rmth_pkg.sv =====
// Shared types and codes for the two-heap running median.
package rmth_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic               op;
        logic signed [31:0] value;
    } item_t;

    typedef struct packed {
        logic signed [31:0] median;
        logic               median_valid;
        logic [10:0]        lower_count;
        logic [10:0]        upper_count;
        logic [1:0]         status;
    } result_t;

endpackage

// ===== design/running_median_two_heaps.sv =====
// Running median over a max-heap and a min-heap sharing one store.
// A rejected item (full insert or empty delete) goes straight to the median read and output;
// otherwise a push checks one parent per level and a pop a pair of children per level.
// One item at a time; worst case near 3 x (log2(CAPACITY) levels) sift passes.
// All store traffic goes through one memory with one read and one write port.
// Reset clears both counts and the output register; the store is not cleared.
module running_median_two_heaps #(
    parameter int CAPACITY = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  rmth_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output rmth_pkg::result_t result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NW = CW + 1;
    localparam int XW = (CW > 11) ? CW : 11;

    typedef enum logic [4:0] {
        S_IDLE, S_CMP_RD, S_CMP, S_PUSH_GO, S_PUSH_RD, S_PUSH_CK, S_PUSH_WR,
        S_POP_GO, S_POP_LAST, S_POP_ISSUE, S_POP_LD, S_POP_RD, S_POP_CMP,
        S_MV_RD, S_MV_D, S_NEXT, S_TOP, S_TOP_D, S_OUT
    } state_t;

    typedef enum logic [1:0] {J_NONE, J_MOVE, J_PUSH2} job_t;

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rdata_reg;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    state_t             state_reg, state_next;
    job_t               job_reg, job_next;
    logic               side_reg, side_next;
    logic [NW-1:0]      idx_reg, idx_next;
    logic [NW-1:0]      midx_reg, midx_next;
    logic signed [31:0] val_reg, val_next;
    logic signed [31:0] lval_reg, lval_next;
    logic signed [31:0] mval_reg, mval_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] med_reg, med_next;
    logic [1:0]         status_reg, status_next;
    logic [CW-1:0]      lower_size_reg, lower_size_next;
    logic [CW-1:0]      upper_size_reg, upper_size_next;
    logic               result_valid_reg, result_valid_next;
    rmth_pkg::result_t  result_reg, result_next;

    logic [CW-1:0]      size_cur;
    logic [NW-1:0]      parent, lchild, rchild, n_cur;
    logic [CW:0]        total;
    logic [XW-1:0]      lc_x, uc_x;

    function automatic logic [AW-1:0] slot(input logic upper, input logic [NW-1:0] node);
        logic [AW-1:0] n;
        n = node[AW-1:0];
        return upper ? (AW'(CAPACITY - 1) - n) : n;
    endfunction

    function automatic logic in_order(input logic upper, input logic signed [31:0] p,
                                      input logic signed [31:0] c);
        return upper ? (p <= c) : (p >= c);
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign size_cur = side_reg ? upper_size_reg : lower_size_reg;
    assign n_cur    = NW'(size_cur);
    assign parent   = (idx_reg - NW'(1)) >> 1;
    assign lchild   = {idx_reg[NW-2:0], 1'b1};
    assign rchild   = lchild + NW'(1);
    assign total    = {1'b0, lower_size_reg} + {1'b0, upper_size_reg};
    assign lc_x     = XW'(lower_size_reg);
    assign uc_x     = XW'(upper_size_reg);

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        job_next          = job_reg;
        side_next         = side_reg;
        idx_next          = idx_reg;
        midx_next         = midx_reg;
        val_next          = val_reg;
        lval_next         = lval_reg;
        mval_next         = mval_reg;
        x_next            = x_reg;
        med_next          = med_reg;
        status_next       = status_reg;
        lower_size_next   = lower_size_reg;
        upper_size_next   = upper_size_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        rd_addr           = '0;
        wr_en             = 1'b0;
        wr_addr           = slot(side_reg, idx_reg);
        wr_data           = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    x_next      = item.value;
                    status_next = rmth_pkg::STATUS_OK;
                    job_next    = J_NONE;
                    if (item.op == rmth_pkg::OP_INSERT)
                    begin
                        if (total >= (CW + 1)'(CAPACITY))
                        begin
                            status_next = rmth_pkg::STATUS_FULL;
                            state_next  = S_TOP;
                        end
                        else if (upper_size_reg == '0)
                        begin
                            side_next  = 1'b1;
                            state_next = S_PUSH_GO;
                        end
                        else
                        begin
                            state_next = S_CMP_RD;
                        end
                    end
                    else
                    begin
                        if (lower_size_reg == '0 && upper_size_reg == '0)
                        begin
                            status_next = rmth_pkg::STATUS_EMPTY;
                            state_next  = S_TOP;
                        end
                        else
                        begin
                            side_next  = (upper_size_reg > lower_size_reg);
                            state_next = S_POP_GO;
                        end
                    end
                end
            end
            S_CMP_RD:
            begin
                rd_addr    = slot(1'b1, '0);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (x_reg > rdata_reg)
                begin
                    side_next = 1'b1;
                    job_next  = (lower_size_reg != upper_size_reg) ? J_MOVE : J_NONE;
                end
                else
                begin
                    side_next = 1'b0;
                    job_next  = (lower_size_reg == upper_size_reg) ? J_MOVE : J_NONE;
                end
                state_next = S_PUSH_GO;
            end
            S_PUSH_GO:
            begin
                idx_next = n_cur;
                val_next = x_reg;
                if (side_reg)
                begin
                    upper_size_next = upper_size_reg + CW'(1);
                end
                else
                begin
                    lower_size_next = lower_size_reg + CW'(1);
                end
                state_next = (size_cur == '0) ? S_PUSH_WR : S_PUSH_RD;
            end
            S_PUSH_RD:
            begin
                rd_addr    = slot(side_reg, parent);
                state_next = S_PUSH_CK;
            end
            S_PUSH_CK:
            begin
                wr_en = 1'b1;
                if (in_order(side_reg, rdata_reg, val_reg))
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    wr_data    = rdata_reg;
                    idx_next   = parent;
                    state_next = (parent == '0) ? S_PUSH_WR : S_PUSH_RD;
                end
            end
            S_PUSH_WR:
            begin
                wr_en      = 1'b1;
                state_next = S_NEXT;
            end
            S_POP_GO:
            begin
                rd_addr = slot(side_reg, n_cur - NW'(1));
                if (side_reg)
                begin
                    upper_size_next = upper_size_reg - CW'(1);
                end
                else
                begin
                    lower_size_next = lower_size_reg - CW'(1);
                end
                state_next = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                val_next   = rdata_reg;
                idx_next   = '0;
                state_next = S_POP_ISSUE;
            end
            S_POP_ISSUE:
            begin
                if (lchild >= n_cur)
                begin
                    wr_en      = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    rd_addr    = slot(side_reg, lchild);
                    state_next = S_POP_LD;
                end
            end
            S_POP_LD:
            begin
                lval_next = rdata_reg;
                if (rchild < n_cur)
                begin
                    rd_addr    = slot(side_reg, rchild);
                    state_next = S_POP_RD;
                end
                else
                begin
                    mval_next  = rdata_reg;
                    midx_next  = lchild;
                    state_next = S_POP_CMP;
                end
            end
            S_POP_RD:
            begin
                if (in_order(side_reg, lval_reg, rdata_reg))
                begin
                    mval_next = lval_reg;
                    midx_next = lchild;
                end
                else
                begin
                    mval_next = rdata_reg;
                    midx_next = rchild;
                end
                state_next = S_POP_CMP;
            end
            S_POP_CMP:
            begin
                wr_en = 1'b1;
                if (in_order(side_reg, val_reg, mval_reg))
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    wr_data    = mval_reg;
                    idx_next   = midx_reg;
                    state_next = S_POP_ISSUE;
                end
            end
            S_MV_RD:
            begin
                rd_addr    = slot(side_reg, '0);
                state_next = S_MV_D;
            end
            S_MV_D:
            begin
                x_next     = rdata_reg;
                job_next   = J_PUSH2;
                state_next = S_POP_GO;
            end
            S_NEXT:
            begin
                case (job_reg)
                    J_MOVE:
                    begin
                        state_next = S_MV_RD;
                    end
                    J_PUSH2:
                    begin
                        side_next  = ~side_reg;
                        job_next   = J_NONE;
                        state_next = S_PUSH_GO;
                    end
                    default:
                    begin
                        state_next = S_TOP;
                    end
                endcase
            end
            S_TOP:
            begin
                rd_addr = slot(1'b1, '0);
                if (upper_size_reg == '0)
                begin
                    med_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_TOP_D;
                end
            end
            S_TOP_D:
            begin
                med_next   = rdata_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.median       = med_reg;
                    result_next.median_valid = (upper_size_reg != '0);
                    result_next.lower_count  = lc_x[10:0];
                    result_next.upper_count  = uc_x[10:0];
                    result_next.status       = status_reg;
                    result_valid_next        = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            job_reg          <= J_NONE;
            side_reg         <= 1'b0;
            idx_reg          <= '0;
            midx_reg         <= '0;
            val_reg          <= '0;
            lval_reg         <= '0;
            mval_reg         <= '0;
            x_reg            <= '0;
            med_reg          <= '0;
            status_reg       <= rmth_pkg::STATUS_OK;
            lower_size_reg   <= '0;
            upper_size_reg   <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            job_reg          <= job_next;
            side_reg         <= side_next;
            idx_reg          <= idx_next;
            midx_reg         <= midx_next;
            val_reg          <= val_next;
            lval_reg         <= lval_next;
            mval_reg         <= mval_next;
            x_reg            <= x_next;
            med_reg          <= med_next;
            status_reg       <= status_next;
            lower_size_reg   <= lower_size_next;
            upper_size_reg   <= upper_size_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

endmodule

// ===== dv/tb_running_median_two_heaps.sv =====
// Testbench for the two-heap running median: queued driver, clocked monitor, built-in predictor.
module tb_running_median_two_heaps;

    localparam int CAP = 1024;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    rmth_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall;
    rmth_pkg::result_t result;

    running_median_two_heaps #(.CAPACITY(CAP)) dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // predictor state
    logic signed [31:0] heap_mem [CAP];
    int unsigned        lo_n;
    int unsigned        up_n;

    rmth_pkg::item_t   pending_items [$];
    rmth_pkg::result_t median_due [$];
    int                errors;
    int                send_idle_pct;
    int                recv_stall_pct;
    bit                hold_send;

    function automatic int unsigned slot(bit upper, int unsigned node);
        return upper ? CAP - 1 - node : node;
    endfunction

    function automatic bit ordered(bit upper, logic signed [31:0] p, logic signed [31:0] c);
        return upper ? (p <= c) : (p >= c);
    endfunction

    task automatic swap_slots(bit upper, int unsigned a, int unsigned b);
        logic signed [31:0] t;
        t = heap_mem[slot(upper, a)];
        heap_mem[slot(upper, a)] = heap_mem[slot(upper, b)];
        heap_mem[slot(upper, b)] = t;
    endtask

    task automatic push_val(bit upper, logic signed [31:0] x);
        int unsigned i;
        int unsigned p;
        i = upper ? up_n : lo_n;
        heap_mem[slot(upper, i)] = x;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (ordered(upper, heap_mem[slot(upper, p)], heap_mem[slot(upper, i)]))
                break;
            swap_slots(upper, p, i);
            i = p;
        end
        if (upper) up_n++; else lo_n++;
    endtask

    task automatic pop_top(bit upper);
        int unsigned n;
        int unsigned i;
        int unsigned l;
        int unsigned m;
        i = 0;
        if (upper)
        begin
            up_n--;
            n = up_n;
        end
        else
        begin
            lo_n--;
            n = lo_n;
        end
        heap_mem[slot(upper, 0)] = heap_mem[slot(upper, n)];
        while (i < n)
        begin
            l = 2 * i + 1;
            if (l >= n) break;
            if (l == n - 1) m = l;
            else m = ordered(upper, heap_mem[slot(upper, l)], heap_mem[slot(upper, l + 1)])
                     ? l : l + 1;
            if (ordered(upper, heap_mem[slot(upper, i)], heap_mem[slot(upper, m)])) break;
            swap_slots(upper, i, m);
            i = m;
        end
    endtask

    task automatic predict_median(rmth_pkg::item_t it);
        rmth_pkg::result_t r;
        logic signed [31:0] t;
        bit eq;
        r = '0;
        r.status = rmth_pkg::STATUS_OK;
        if (it.op == rmth_pkg::OP_INSERT)
        begin
            if (lo_n + up_n >= CAP)
                r.status = rmth_pkg::STATUS_FULL;
            else if (up_n == 0)
                push_val(1'b1, it.value);
            else if (it.value > heap_mem[slot(1'b1, 0)])
            begin
                push_val(1'b1, it.value);
                if (lo_n != up_n - 1)
                begin
                    t = heap_mem[slot(1'b1, 0)];
                    pop_top(1'b1);
                    push_val(1'b0, t);
                end
            end
            else
            begin
                eq = (lo_n == up_n);
                push_val(1'b0, it.value);
                if (eq)
                begin
                    t = heap_mem[slot(1'b0, 0)];
                    pop_top(1'b0);
                    push_val(1'b1, t);
                end
            end
        end
        else
        begin
            if (lo_n == 0 && up_n == 0) r.status = rmth_pkg::STATUS_EMPTY;
            else if (up_n > lo_n) pop_top(1'b1);
            else pop_top(1'b0);
        end
        r.median       = (up_n > 0) ? heap_mem[slot(1'b1, 0)] : 32'sd0;
        r.median_valid = (up_n > 0);
        r.lower_count  = lo_n[10:0];
        r.upper_count  = up_n[10:0];
        median_due.push_back(r);
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (item_valid) predict_median(item);
            if (pending_items.size() > 0 && !hold_send && $urandom_range(99) >= send_idle_pct)
            begin
                item_valid <= 1'b1;
                item       <= pending_items.pop_front();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        rmth_pkg::result_t w;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (median_due.size() == 0)
                begin
                    report("unexpected transfer", 64'(result), 64'd0);
                end
                else
                begin
                    w = median_due.pop_front();
                    if (result.median !== w.median) report("median", result.median, w.median);
                    if (result.median_valid !== w.median_valid)
                        report("median_valid", result.median_valid, w.median_valid);
                    if (result.lower_count !== w.lower_count)
                        report("lower_count", result.lower_count, w.lower_count);
                    if (result.upper_count !== w.upper_count)
                        report("upper_count", result.upper_count, w.upper_count);
                    if (result.status !== w.status) report("status", result.status, w.status);
                end
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed(32'($urandom_range(20))) - 10;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic add(logic o, logic signed [31:0] v);
        rmth_pkg::item_t it;
        it.op = o;
        it.value = v;
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || item_valid || median_due.size() > 0)
            @(posedge clk);
    endtask

    // mostly inserts, so the store climbs towards full across the phases
    task automatic phase(int n, int sidle, int rstall);
        int k;
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        for (k = 0; k < n; k++)
            add(($urandom_range(99) < 1) ? rmth_pkg::OP_DELETE : rmth_pkg::OP_INSERT,
                rand_val());
        drain();
    endtask

    initial
    begin
        int k;
        int fill;
        errors = 0; hold_send = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        lo_n = 0; up_n = 0;
        rst_n = 1'b0;
        item_valid = 1'b0; item = '0; result_stall = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: empty delete, extremes, ties
        add(rmth_pkg::OP_DELETE, 32'sh7fff_ffff);
        add(rmth_pkg::OP_INSERT, 32'sh8000_0000);
        add(rmth_pkg::OP_INSERT, 32'sh7fff_ffff);
        add(rmth_pkg::OP_INSERT, 32'sd0);
        add(rmth_pkg::OP_INSERT, 32'sd0);
        add(rmth_pkg::OP_INSERT, 32'sd0);
        add(rmth_pkg::OP_INSERT, -32'sd1);
        add(rmth_pkg::OP_INSERT, 32'sd5);
        add(rmth_pkg::OP_INSERT, 32'sd5);
        for (k = 0; k < 10; k++) add(rmth_pkg::OP_DELETE, 32'sh5555_aaaa);
        drain();
        // hold the driver back for a pause while idle, then continue
        hold_send = 1;
        repeat (20) @(posedge clk);
        hold_send = 0;
        phase(250, 0, 0);
        phase(250, 45, 0);
        phase(250, 0, 45);
        phase(250, 21, 21);
        // top up to capacity, overflow, then a few deletes
        send_idle_pct = 0; recv_stall_pct = 10;
        fill = CAP + 4 - int'(lo_n + up_n);
        for (k = 0; k < fill; k++) add(rmth_pkg::OP_INSERT, rand_val());
        for (k = 0; k < 10; k++) add(rmth_pkg::OP_DELETE, $signed($urandom));
        drain();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
